// File: design/atan2q_pkg.sv
// ----------------------------------------------------------------------------
// atan2q_pkg
// Shared constants, types and the arctangent table of the quadrant angle
// block.
// ----------------------------------------------------------------------------
package atan2q_pkg;

	// defaults of the top level parameters
	localparam int DEF_ITERATIONS = 16;
	localparam int DEF_DATA_WIDTH = 16;

	// fixed formats
	localparam int GUARD_BITS = 24;
	localparam int TABLE_LEN  = 24;
	localparam int DZ_W       = 15;
	localparam int ANGLE_W    = 16;
	localparam int Z_W        = 33;
	localparam int ROUND_SH   = 17;

	// vector width: input plus guard bits plus headroom for the cordic gain
	localparam int DEF_X_W = DEF_DATA_WIDTH + GUARD_BITS + 3;

	localparam logic signed [ANGLE_W:0] PI_Q13      = 17'sd25736;
	localparam logic signed [ANGLE_W:0] HALF_PI_Q13 = 17'sd12868;

	// round(atan(2^-i) * 2^30)
	localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
		32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
		32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
		32'd262144,    32'd131072,    32'd65536,     32'd32768,
		32'd16384,     32'd8192,      32'd4096,      32'd2048,
		32'd1024,      32'd512,       32'd256,       32'd128
	};

	// fixed answer when the adjacent side is in the dead zone
	typedef enum logic [1:0] {
		FIX_ZERO     = 2'd0,
		FIX_POS_HALF = 2'd1,
		FIX_NEG_HALF = 2'd2
	} fix_t;

	// quadrant correction after the rotation
	typedef enum logic [1:0] {
		QUAD_NONE   = 2'd0,
		QUAD_ADD_PI = 2'd1,
		QUAD_SUB_PI = 2'd2
	} quad_t;

	// sideband that travels with each beat down the chain
	typedef struct packed {
		logic  bypass;
		fix_t  fix;
		quad_t quad;
	} ctrl_t;

endpackage

// File: design/atan2q_prep.sv
// ----------------------------------------------------------------------------
// atan2q_prep
// Entry stage: dead-zone decision, fold into the right half plane and scale
// the vector by the guard bits.
// ----------------------------------------------------------------------------
module atan2q_prep import atan2q_pkg::*; #(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH,
	parameter int X_W        = DEF_X_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [DZ_W-1:0]              dead_zone,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] opposite,
	input  logic signed [DATA_WIDTH-1:0] adjacent,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [X_W-1:0]        x_out,
	output logic signed [X_W-1:0]        y_out,
	output ctrl_t                        ctrl_out
);

	localparam int CW = (DATA_WIDTH > DZ_W) ? DATA_WIDTH + 2 : DZ_W + 2;

	logic signed [DATA_WIDTH:0] x_e, y_e, x_f, y_f, ax;
	logic signed [CW-1:0]       ax_c, y_c, dz_c;
	logic                       neg;
	ctrl_t                      ctrl_d;

	logic                  valid_s1;
	logic signed [X_W-1:0] x_s1, y_s1;
	ctrl_t                 ctrl_s1;

	// fold and classify
	always_comb begin
		x_e  = (DATA_WIDTH+1)'(adjacent);
		y_e  = (DATA_WIDTH+1)'(opposite);
		neg  = adjacent[DATA_WIDTH-1];
		x_f  = neg ? -x_e : x_e;
		y_f  = neg ? -y_e : y_e;
		ax   = x_f;
		ax_c = CW'(ax);
		y_c  = CW'(y_e);
		dz_c = $signed(CW'(dead_zone));
		ctrl_d.bypass = (ax_c <= dz_c);
		if (y_c > dz_c) begin
			ctrl_d.fix = FIX_POS_HALF;
		end else if (y_c < -dz_c) begin
			ctrl_d.fix = FIX_NEG_HALF;
		end else begin
			ctrl_d.fix = FIX_ZERO;
		end
		if (!neg) begin
			ctrl_d.quad = QUAD_NONE;
		end else if (opposite[DATA_WIDTH-1]) begin
			ctrl_d.quad = QUAD_SUB_PI;
		end else begin
			ctrl_d.quad = QUAD_ADD_PI;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	// stage register, valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage register, payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_s1    <= X_W'(x_f) <<< GUARD_BITS;
			y_s1    <= X_W'(y_f) <<< GUARD_BITS;
			ctrl_s1 <= ctrl_d;
		end
	end

	assign out_valid = valid_s1;
	assign x_out     = x_s1;
	assign y_out     = y_s1;
	assign ctrl_out  = ctrl_s1;

endmodule

// File: design/atan2q_cell.sv
// ----------------------------------------------------------------------------
// atan2q_cell
// One vectoring rotation step of the chain, with its own stage register.
// ----------------------------------------------------------------------------
module atan2q_cell import atan2q_pkg::*; #(
	parameter int X_W = DEF_X_W,
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [X_W-1:0] x_in,
	input  logic signed [X_W-1:0] y_in,
	input  logic signed [Z_W-1:0] z_in,
	input  ctrl_t                 ctrl_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [X_W-1:0] x_out,
	output logic signed [X_W-1:0] y_out,
	output logic signed [Z_W-1:0] z_out,
	output ctrl_t                 ctrl_out
);

	localparam logic signed [Z_W-1:0] ENTRY =
		$signed({{(Z_W-32){1'b0}}, ATAN_TAB[IDX]});

	logic signed [X_W-1:0] xs, ys, x_d, y_d;
	logic signed [Z_W-1:0] z_d;

	logic                  valid_s1;
	logic signed [X_W-1:0] x_s1, y_s1;
	logic signed [Z_W-1:0] z_s1;
	ctrl_t                 ctrl_s1;

	// rotate toward the x axis
	always_comb begin
		xs = x_in >>> IDX;
		ys = y_in >>> IDX;
		if (!y_in[X_W-1]) begin
			x_d = x_in + ys;
			y_d = y_in - xs;
			z_d = z_in + ENTRY;
		end else begin
			x_d = x_in - ys;
			y_d = y_in + xs;
			z_d = z_in - ENTRY;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	// stage register, valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage register, payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_s1    <= x_d;
			y_s1    <= y_d;
			z_s1    <= z_d;
			ctrl_s1 <= ctrl_in;
		end
	end

	assign out_valid = valid_s1;
	assign x_out     = x_s1;
	assign y_out     = y_s1;
	assign z_out     = z_s1;
	assign ctrl_out  = ctrl_s1;

endmodule

// File: design/atan2q_post.sv
// ----------------------------------------------------------------------------
// atan2q_post
// Exit stage: round the accumulated angle to Q3.13, apply the quadrant
// term, saturate, or pick the dead-zone answer.
// ----------------------------------------------------------------------------
module atan2q_post import atan2q_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [Z_W-1:0]     z_in,
	input  ctrl_t                     ctrl_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [ANGLE_W-1:0] angle
);

	localparam logic signed [Z_W-1:0] HALF_LSB = Z_W'(1) <<< (ROUND_SH - 1);

	logic signed [Z_W-1:0]     z_r;
	logic signed [ANGLE_W:0]   a_r, a_q, a_sat;
	logic signed [ANGLE_W-1:0] ang_d;

	logic                      valid_s1;
	logic signed [ANGLE_W-1:0] angle_s1;

	// round, correct quadrant, saturate
	always_comb begin
		z_r = z_in + HALF_LSB;
		a_r = (ANGLE_W+1)'($signed(z_r[Z_W-1:ROUND_SH]));
		unique case (ctrl_in.quad)
			QUAD_ADD_PI: a_q = a_r + PI_Q13;
			QUAD_SUB_PI: a_q = a_r - PI_Q13;
			default:     a_q = a_r;
		endcase
		if (a_q > PI_Q13) begin
			a_sat = PI_Q13;
		end else if (a_q < -PI_Q13) begin
			a_sat = -PI_Q13;
		end else begin
			a_sat = a_q;
		end
		if (ctrl_in.bypass) begin
			unique case (ctrl_in.fix)
				FIX_POS_HALF: ang_d = ANGLE_W'(HALF_PI_Q13);
				FIX_NEG_HALF: ang_d = ANGLE_W'(-HALF_PI_Q13);
				default:      ang_d = '0;
			endcase
		end else begin
			ang_d = a_sat[ANGLE_W-1:0];
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	// output register, valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// output register, payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			angle_s1 <= ang_d;
		end
	end

	assign out_valid = valid_s1;
	assign angle     = angle_s1;

endmodule

// File: design/atan2_quadrant_angle.sv
// ----------------------------------------------------------------------------
// atan2_quadrant_angle
// Four-quadrant arctangent of (opposite, adjacent), signed Q1.15 in, angle
// in radians as signed Q3.13 out, through a chain of rotation cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (opposite, adjacent) arrive on in_valid/in_ready, angle
//   beats leave on out_valid/out_ready; one angle per input, in order.
//   The dead_zone register is written through cfg_valid/cfg_ready/cfg_data,
//   always ready; write it only while no beat is in flight.
//   The path runs through one entry stage, one cell per rotation step and
//   one output stage. Throughput is one beat per cycle while the receiver
//   takes beats; every cell of the chain holds one beat in its own register.
//   Each stage advances when its register is empty or the next stage takes
//   its beat, so a stalled receiver backs the chain up stage by stage and
//   in_ready drops only when every stage is full; bubbles keep filling.
//   Reset clears all stage valid bits and sets dead_zone to zero.
// ----------------------------------------------------------------------------
module atan2_quadrant_angle import atan2q_pkg::*; #(
	parameter int ITERATIONS = DEF_ITERATIONS,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [DZ_W-1:0]              cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] opposite,
	input  logic signed [DATA_WIDTH-1:0] adjacent,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [ANGLE_W-1:0]    angle
);

	localparam int X_W = DATA_WIDTH + GUARD_BITS + 3;

	logic [DZ_W-1:0] dead_zone_q;

	logic                  v_c [ITERATIONS+1];
	logic                  r_c [ITERATIONS+1];
	logic signed [X_W-1:0] x_c [ITERATIONS+1];
	logic signed [X_W-1:0] y_c [ITERATIONS+1];
	logic signed [Z_W-1:0] z_c [ITERATIONS+1];
	ctrl_t                 k_c [ITERATIONS+1];

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			dead_zone_q <= cfg_data;
		end
	end

	// entry stage
	atan2q_prep #(
		.DATA_WIDTH(DATA_WIDTH),
		.X_W       (X_W)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.dead_zone(dead_zone_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opposite (opposite),
		.adjacent (adjacent),
		.out_valid(v_c[0]),
		.out_ready(r_c[0]),
		.x_out    (x_c[0]),
		.y_out    (y_c[0]),
		.ctrl_out (k_c[0])
	);

	// angle accumulator starts at zero
	assign z_c[0] = '0;

	// chain of rotation cells
	for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
		atan2q_cell #(
			.X_W(X_W),
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v_c[i]),
			.in_ready (r_c[i]),
			.x_in     (x_c[i]),
			.y_in     (y_c[i]),
			.z_in     (z_c[i]),
			.ctrl_in  (k_c[i]),
			.out_valid(v_c[i+1]),
			.out_ready(r_c[i+1]),
			.x_out    (x_c[i+1]),
			.y_out    (y_c[i+1]),
			.z_out    (z_c[i+1]),
			.ctrl_out (k_c[i+1])
		);
	end

	// exit stage
	atan2q_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_c[ITERATIONS]),
		.in_ready (r_c[ITERATIONS]),
		.z_in     (z_c[ITERATIONS]),
		.ctrl_in  (k_c[ITERATIONS]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.angle    (angle)
	);

endmodule

// File: tb/tb_atan2_quadrant_angle.sv
// ----------------------------------------------------------------------------
// tb_atan2_quadrant_angle
// Self-checking bench for the four-quadrant arctangent. A short table of
// directed beats covers the dead zone edges, the axes and the input extremes.
// Random beats follow over several dead zone settings. Every angle is checked
// in order against its hand-known value or a cycle-free CORDIC predictor. The
// sender works in random bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_atan2_quadrant_angle;
	timeunit 1ns;
	timeprecision 1ps;

	import atan2q_pkg::*;

	localparam int DW          = DEF_DATA_WIDTH;
	localparam int QUIET_LIMIT = 5000;
	localparam int MAX_REPORTS = 10;
	localparam int PHASES      = 5;
	localparam int PHASE_BEATS = 110;
	localparam longint ROUND_HALF = 64'sd1 <<< (ROUND_SH - 1);

	// one directed beat, with its angle where it is known by hand
	typedef struct packed {
		logic [DZ_W-1:0]           dz;
		logic signed [DW-1:0]      opp;
		logic signed [DW-1:0]      adj;
		logic                      known;
		logic signed [ANGLE_W-1:0] ang;
	} dir_row_t;

	// an angle waiting for its output beat, with the inputs behind it
	typedef struct packed {
		logic signed [DW-1:0]      opp;
		logic signed [DW-1:0]      adj;
		logic [DZ_W-1:0]           dz;
		logic signed [ANGLE_W-1:0] ang;
	} angle_exp_t;

	localparam int PLAN_LEN = 25;
	localparam dir_row_t PLAN [PLAN_LEN] = '{
		// dead zone zero, just after reset
		'{15'd0,     16'sd0,      16'sd0,      1'b1, 16'sd0},
		'{15'd0,     16'sd1,      16'sd0,      1'b1, 16'sd12868},
		'{15'd0,    -16'sd1,      16'sd0,      1'b1, -16'sd12868},
		'{15'd0,     16'sd32767,  16'sd0,      1'b1, 16'sd12868},
		'{15'd0,    -16'sd32768,  16'sd0,      1'b1, -16'sd12868},
		'{15'd0,     16'sd0,      16'sd32767,  1'b1, 16'sd0},
		'{15'd0,     16'sd0,     -16'sd32768,  1'b1, 16'sd25736},
		'{15'd0,     16'sd0,     -16'sd1,      1'b1, 16'sd25736},
		'{15'd0,     16'sd32767,  16'sd32767,  1'b0, 16'sd0},
		'{15'd0,    -16'sd32768, -16'sd32768,  1'b0, 16'sd0},
		'{15'd0,     16'sd32767, -16'sd32768,  1'b0, 16'sd0},
		'{15'd0,    -16'sd32768,  16'sd32767,  1'b0, 16'sd0},
		'{15'd0,    -16'sd1,     -16'sd32768,  1'b0, 16'sd0},
		'{15'd0,     16'sd1,     -16'sd32768,  1'b0, 16'sd0},
		'{15'd0,     16'sd32767,  16'sd1,      1'b0, 16'sd0},
		// widest dead zone
		'{15'd32767, 16'sd32767,  16'sd32767,  1'b1, 16'sd0},
		'{15'd32767,-16'sd32768,  16'sd0,      1'b1, -16'sd12868},
		'{15'd32767,-16'sd32767, -16'sd32767,  1'b1, 16'sd0},
		'{15'd32767, 16'sd5,     -16'sd32768,  1'b0, 16'sd0},
		'{15'd32767,-16'sd5,     -16'sd32768,  1'b0, 16'sd0},
		// dead zone edges, and the quadrant sign test inside the zone
		'{15'd100,   16'sd101,    16'sd100,    1'b1, 16'sd12868},
		'{15'd100,  -16'sd101,   -16'sd100,    1'b1, -16'sd12868},
		'{15'd100,   16'sd100,   -16'sd100,    1'b1, 16'sd0},
		'{15'd100,   16'sd0,     -16'sd101,    1'b1, 16'sd25736},
		'{15'd100,  -16'sd3,     -16'sd101,    1'b0, 16'sd0}
	};

	logic                      clk;
	logic                      arst_n      = 1'b0;
	logic                      cfg_valid   = 1'b0;
	logic                      cfg_ready;
	logic [DZ_W-1:0]           cfg_data    = '0;
	logic                      in_valid    = 1'b0;
	logic                      in_ready;
	logic signed [DW-1:0]      opposite    = '0;
	logic signed [DW-1:0]      adjacent    = '0;
	logic                      out_valid;
	logic                      out_ready   = 1'b0;
	logic signed [ANGLE_W-1:0] angle;

	// hand-known angle that travels with the current input beat
	logic                      typed_known = 1'b0;
	logic signed [ANGLE_W-1:0] typed_angle = '0;

	angle_exp_t      angle_q [$];
	logic [DZ_W-1:0] dz_now = '0;   // dead zone as the block holds it
	logic [DZ_W-1:0] dz_drv = '0;   // dead zone as the sender last wrote it
	int              mismatches = 0;
	int              quiet_cycles = 0;
	int              burst_left = 0;
	int              rx_mode = 0;
	int              rx_mode_left = 0;

	atan2_quadrant_angle dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opposite  (opposite),
		.adjacent  (adjacent),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.angle     (angle)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// angle of (adj, opp) in Q3.13 under dead zone dz
	function automatic logic signed [ANGLE_W-1:0] atan2_q13(
		input logic signed [DW-1:0] opp,
		input logic signed [DW-1:0] adj,
		input logic [DZ_W-1:0]      dz_val
	);
		longint y, x, dz, mag, vx, vy, step_x, step_y, z, entry, ang;
		y   = opp;
		x   = adj;
		dz  = dz_val;
		mag = (x < 0) ? -x : x;
		if (mag <= dz) begin
			if (y > dz)
				ang = HALF_PI_Q13;
			else if (y < -dz)
				ang = -HALF_PI_Q13;
			else
				ang = 0;
		end else begin
			// fold the left half plane onto the right, same ratio
			vx = mag <<< GUARD_BITS;
			vy = ((x < 0) ? -y : y) <<< GUARD_BITS;
			z  = 0;
			for (int i = 0; i < DEF_ITERATIONS && i < TABLE_LEN; i++) begin
				step_x = vx >>> i;
				step_y = vy >>> i;
				entry  = ATAN_TAB[i];
				if (vy >= 0) begin
					vx = vx + step_y;
					vy = vy - step_x;
					z  = z + entry;
				end else begin
					vx = vx - step_y;
					vy = vy + step_x;
					z  = z - entry;
				end
			end
			ang = (z + ROUND_HALF) >>> ROUND_SH;
			// quadrant correction on the exact sign of y
			if (x < 0)
				ang = (y < 0) ? ang - PI_Q13 : ang + PI_Q13;
			if (ang > PI_Q13)
				ang = PI_Q13;
			if (ang < -PI_Q13)
				ang = -PI_Q13;
		end
		return ang[ANGLE_W-1:0];
	endfunction

	// clamp an integer into the input field range
	function automatic logic signed [DW-1:0] to_field(input int v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return v[DW-1:0];
	endfunction

	// one input beat, with a burst gap ahead of it now and then
	task automatic send_beat(
		input logic signed [DW-1:0]      opp,
		input logic signed [DW-1:0]      adj,
		input logic                      known,
		input logic signed [ANGLE_W-1:0] ang
	);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		in_valid    <= 1'b1;
		opposite    <= opp;
		adjacent    <= adj;
		typed_known <= known;
		typed_angle <= ang;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// drain every angle in flight, then write the dead zone
	task automatic set_dead_zone(input logic [DZ_W-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (angle_q.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		dz_drv = v;
	endtask

	// random beat, weighted toward dead zone edges, axes and extremes
	task automatic pick_beat(
		output logic signed [DW-1:0] opp,
		output logic signed [DW-1:0] adj
	);
		int edges [5];
		int dz, v;
		edges = '{-32768, -1, 0, 1, 32767};
		dz    = dz_drv;
		opp   = DW'($urandom_range(0, 65535));
		adj   = DW'($urandom_range(0, 65535));
		case ($urandom_range(0, 9))
			6: begin
				// adjacent just around the zone edge
				v   = dz + $urandom_range(0, 4) - 2;
				v   = (v < 0) ? 0 : v;
				adj = to_field($urandom_range(0, 1) ? v : -v);
			end
			7: begin
				// adjacent inside the zone, opposite around its edge
				adj = to_field($urandom_range(0, 1) ? $urandom_range(0, dz) : -$urandom_range(0, dz));
				v   = dz + $urandom_range(0, 4) - 2;
				opp = to_field($urandom_range(0, 1) ? v : -v);
			end
			8: opp = to_field($urandom_range(0, 2) - 1);
			9: begin
				opp = to_field(edges[$urandom_range(0, 4)]);
				adj = to_field(edges[$urandom_range(0, 4)]);
			end
			default: ;
		endcase
	endtask

	// receiver stall pattern: free running, coin flips, or mostly stalled
	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode      <= $urandom_range(0, 2);
			rx_mode_left <= $urandom_range(20, 200);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		case (rx_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= $urandom_range(0, 1);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// check each output beat, then log the expectation of each input beat
	always @(posedge clk) begin
		angle_exp_t hit;
		angle_exp_t fresh;
		if (out_valid && out_ready) begin
			if (angle_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected angle beat: angle=%0d", angle);
			end else begin
				hit = angle_q.pop_front();
				if (angle !== hit.ang) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("angle mismatch: opp=%0d adj=%0d dz=%0d expected=%0d actual=%0d",
							hit.opp, hit.adj, hit.dz, hit.ang, angle);
				end
			end
		end
		if (in_valid && in_ready) begin
			fresh.opp = opposite;
			fresh.adj = adjacent;
			fresh.dz  = dz_now;
			fresh.ang = typed_known ? typed_angle : atan2_q13(opposite, adjacent, dz_now);
			angle_q.push_back(fresh);
		end
		if (cfg_valid && cfg_ready)
			dz_now <= cfg_data;
	end

	// watchdog on cycles where no channel moves a beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_atan2_quadrant_angle failed");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		logic signed [DW-1:0] ry, rx;
		logic [DZ_W-1:0]      phase_dz [PHASES];
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < PLAN_LEN; r++) begin
			if (PLAN[r].dz != dz_drv)
				set_dead_zone(PLAN[r].dz);
			send_beat(PLAN[r].opp, PLAN[r].adj, PLAN[r].known, PLAN[r].ang);
		end

		// random phases over several dead zone settings
		phase_dz[0] = '0;
		phase_dz[1] = DZ_W'($urandom_range(1, 63));
		phase_dz[2] = DZ_W'($urandom_range(0, 32767));
		phase_dz[3] = 15'd32767;
		phase_dz[4] = DZ_W'($urandom_range(0, 2047));
		for (int p = 0; p < PHASES; p++) begin
			set_dead_zone(phase_dz[p]);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				pick_beat(ry, rx);
				send_beat(ry, rx, 1'b0, '0);
			end
		end

		// let the chain drain, then settle
		in_valid <= 1'b0;
		@(posedge clk);
		while (angle_q.size() != 0) @(posedge clk);
		repeat (DEF_ITERATIONS + 4) @(posedge clk);
		if (mismatches == 0)
			$display("tb_atan2_quadrant_angle passed");
		else
			$display("tb_atan2_quadrant_angle failed");
		$finish;
	end

endmodule

// File: atan2_quadrant_angle.f
design/atan2q_pkg.sv
design/atan2q_prep.sv
design/atan2q_cell.sv
design/atan2q_post.sv
design/atan2_quadrant_angle.sv
tb/tb_atan2_quadrant_angle.sv
